FILE: hdl/xsd_pkg.sv
package xsd_pkg;

    // command codes
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LORES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP  = 1'b1;

    // result field widths
    localparam int FLAG_W = 5;
    localparam int READ_W = 64;
    localparam logic [FLAG_W-1:0] FLAG_MAX = 5'd31;

    // per-item control carried from the position stage to the draw stage
    typedef struct packed {
        logic is_read;
        logic draw;
        logic doubled;
        logic wide;
        logic wrap;
        logic clear;
        logic clip;
    } ctl_t;

    // doubles every bit of a byte, bit 7 lands in bits 15 and 14
    function automatic logic [15:0] spread_byte(input logic [7:0] b);
        logic [15:0] r;
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r[2*i]   = b[i];
            r[2*i+1] = b[i];
        end
        return r;
    endfunction

endpackage

FILE: hdl/xsd_if.sv
// request channel: one draw or read command per item
interface xsd_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [15:0] row_data;
    logic        wide;
    logic        first_row;

    modport source (output valid, command, x_coord, y_coord, row_data, wide, first_row,
                    input ready);
    modport sink (input valid, command, x_coord, y_coord, row_data, wide, first_row,
                  output ready);
endinterface

// response channel: one result per command item
interface xsd_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [xsd_pkg::FLAG_W-1:0] flag_value;
    logic [xsd_pkg::READ_W-1:0] read_data;
    logic                       stopped;

    modport source (output valid, flag_value, read_data, stopped, input ready);
    modport sink (input valid, flag_value, read_data, stopped, output ready);
endinterface

FILE: hdl/xsd_fb.sv
module xsd_fb #(
    parameter int LINE_W = 128,
    parameter int DEPTH  = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [LINE_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [LINE_W-1:0]        rdata0,
    output logic [LINE_W-1:0]        rdata1
);

    logic [LINE_W-1:0] mem [DEPTH];
    logic [LINE_W-1:0] q0_reg;
    logic [LINE_W-1:0] q1_reg;
    logic [LINE_W-1:0] byp_data_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic              v0_reg;
    logic              v1_reg;
    logic              byp0_reg;
    logic              byp1_reg;

    // line storage, registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            q0_reg <= mem[raddr0];
            q1_reg <= mem[raddr1];
        end
    end

    // written-line flags, a line never written reads as cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            byp0_reg  <= 1'b0;
            byp1_reg  <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                v0_reg   <= valid_reg[raddr0];
                v1_reg   <= valid_reg[raddr1];
                byp0_reg <= we && (waddr == raddr0);
                byp1_reg <= we && (waddr == raddr1);
            end
        end
    end

    // write data captured for a read of the line written on the same edge
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            byp_data_reg <= wdata;
        end
    end

    assign rdata0 = byp0_reg ? byp_data_reg : (v0_reg ? q0_reg : '0);
    assign rdata1 = byp1_reg ? byp_data_reg : (v1_reg ? q1_reg : '0);

endmodule

FILE: hdl/xsd_draw.sv
module xsd_draw #(
    parameter int LINE_W = 128
) (
    input  xsd_pkg::ctl_t               ctl,
    input  logic [$clog2(LINE_W)-1:0]   x,
    input  logic                        half,
    input  logic [15:0]                 data,
    input  logic [LINE_W-1:0]           line0,
    input  logic [LINE_W-1:0]           line1,
    input  logic [xsd_pkg::FLAG_W-1:0]  coll,
    output logic [LINE_W-1:0]           new0,
    output logic [LINE_W-1:0]           new1,
    output logic [xsd_pkg::FLAG_W-1:0]  coll_next,
    output logic [xsd_pkg::READ_W-1:0]  read_data
);

    localparam int XW = $clog2(LINE_W);

    logic [LINE_W-1:0]          tog;
    logic [LINE_W-1:0]          rng;
    logic [7:0]                 bits_l;
    logic [15:0]                bits_d;
    logic [7:0]                 xr;
    logic [7:0]                 pos;
    logic                       inb;
    logic                       hit;
    logic [xsd_pkg::FLAG_W-1:0] base;
    logic [127:0]               pix_ext;
    logic [6:0]                 ridx;

    // toggle and copy masks over the line for this row
    always_comb
    begin
        tog    = '0;
        rng    = '0;
        bits_l = ctl.wide ? data[15:8] : data[7:0];
        bits_d = xsd_pkg::spread_byte(data[7:0]);
        xr     = 8'(x) + 8'd8;
        pos    = '0;
        inb    = 1'b0;
        for (int i = 0; i < 16; i++)
        begin
            pos = 8'(x) + 8'(i);
            inb = ctl.wrap || (pos < 8'(LINE_W));
            if (ctl.doubled)
            begin
                if ((bits_d != 16'd0) && inb)
                begin
                    rng[pos[XW-1:0]] = 1'b1;
                end
                if (bits_d[15-i] && inb)
                begin
                    tog[pos[XW-1:0]] = 1'b1;
                end
            end
            else if (i < 8)
            begin
                if (bits_l[(7-i)%8] && inb)
                begin
                    tog[pos[XW-1:0]] = 1'b1;
                end
            end
            else
            begin
                // right byte, skipped when it starts past the last column
                if (ctl.wide && (xr < 8'(LINE_W)) && data[15-i] && inb)
                begin
                    tog[pos[XW-1:0]] = 1'b1;
                end
            end
        end
        if (!ctl.draw)
        begin
            tog = '0;
            rng = '0;
        end
    end

    // xor the row in, the second line copies the drawn span
    assign hit  = |(tog & line0);
    assign new0 = line0 ^ tog;
    assign new1 = (line1 & ~rng) | (new0 & rng);

    // collision value
    always_comb
    begin
        base = ctl.clear ? '0 : coll;
        coll_next = base;
        if (ctl.draw && hit)
        begin
            if (ctl.doubled)
            begin
                coll_next = xsd_pkg::FLAG_W'(1);
            end
            else if (base < xsd_pkg::FLAG_MAX)
            begin
                coll_next = base + xsd_pkg::FLAG_W'(1);
            end
        end
    end

    // read: 64 pixels of one half, leftmost in the top bit
    always_comb
    begin
        pix_ext   = 128'(line0);
        read_data = '0;
        ridx      = '0;
        for (int i = 0; i < 64; i++)
        begin
            ridx = {half, 6'(i)};
            read_data[63-i] = ctl.is_read & pix_ext[ridx];
        end
    end

endmodule

FILE: hdl/xor_sprite_draw_collision.sv
// XOR sprite drawing into a 1-bit frame store with collision count.
// Request channel (req): draw one sprite row (command 0) or read 64 pixels
// of one line (command 1). Response channel (rsp): one result per request
// with the collision value, the read pixels (0 for draws) and the stop flag.
// Configuration (cfg_wr_en/cfg_index/cfg_data): lores_doubled at index 0,
// wrap_sprites at index 1; write only while no item is in flight.
// A normal row or a read moves from the draw stage into the result register;
// a doubled row stays in the draw stage for a second phase because it
// writes two frame lines through the single write port.
// Throughput: one item per cycle for normal rows and reads while rsp takes
// results; a doubled row holds req.ready low during its first phase.
// Reset: draw position, collision value and stop flag clear; every frame
// line reads as blank at once through per-line written flags, no clearing
// pass. When rsp stalls, the result register holds, the draw stage holds
// one more item, and req.ready falls until the result is taken.
module xor_sprite_draw_collision #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [xsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                            cfg_data,
    xsd_req_if.sink                         req,
    xsd_rsp_if.source                       rsp
);

    localparam int XW = $clog2(DISPLAY_WIDTH);
    localparam int YW = $clog2(DISPLAY_HEIGHT);
    localparam logic [YW-1:0] Y_LAST  = YW'(DISPLAY_HEIGHT - 1);
    localparam logic [YW-1:0] Y_LAST2 = YW'(DISPLAY_HEIGHT - 2);

    // configuration and draw state
    logic                       lores_reg;
    logic                       wrap_reg;
    logic [XW-1:0]              dx_reg;
    logic [XW-1:0]              dx_next;
    logic [YW-1:0]              dy_reg;
    logic [YW-1:0]              dy_next;
    logic                       clip_reg;
    logic                       clip_next;
    logic [xsd_pkg::FLAG_W-1:0] coll_reg;

    // position stage
    logic [XW-1:0]              a_x0;
    logic [YW-1:0]              a_y0;
    logic [XW-1:0]              a_cx;
    logic [YW-1:0]              a_cy;
    logic                       a_clip;
    logic [YW-1:0]              a_raddr0;
    logic [YW-1:0]              a_raddr1;
    xsd_pkg::ctl_t              a_ctl;
    logic                       accept;

    // draw stage
    logic                       b_valid_reg;
    logic                       b_phase_reg;
    xsd_pkg::ctl_t              b_ctl_reg;
    logic [XW-1:0]              b_x_reg;
    logic [YW-1:0]              b_y_reg;
    logic [YW-1:0]              b_y2_reg;
    logic                       b_half_reg;
    logic [15:0]                b_data_reg;
    logic                       b_two;
    logic                       b_done;
    logic                       b_adv;
    logic                       out_free;

    // frame store and draw datapath
    logic                       fb_we;
    logic [YW-1:0]              fb_waddr;
    logic [DISPLAY_WIDTH-1:0]   fb_wdata;
    logic [DISPLAY_WIDTH-1:0]   line0;
    logic [DISPLAY_WIDTH-1:0]   line1;
    logic [DISPLAY_WIDTH-1:0]   new0;
    logic [DISPLAY_WIDTH-1:0]   new1;
    logic [xsd_pkg::FLAG_W-1:0] coll_next;
    logic [xsd_pkg::READ_W-1:0] rdata;

    // result register
    logic                       o_valid_reg;
    logic [xsd_pkg::FLAG_W-1:0] o_flag_reg;
    logic [xsd_pkg::READ_W-1:0] o_rdata_reg;
    logic                       o_stopped_reg;

    // handshake
    assign out_free  = !o_valid_reg || rsp.ready;
    assign b_two     = b_ctl_reg.draw && b_ctl_reg.doubled;
    assign b_done    = b_valid_reg && (!b_two || b_phase_reg);
    assign b_adv     = b_done && out_free;
    assign req.ready = !b_valid_reg || b_adv;
    assign accept    = req.valid && req.ready;

    // position stage: start point, clipping and next line
    always_comb
    begin
        a_x0 = lores_reg ? XW'({req.x_coord, 1'b0}) : req.x_coord[XW-1:0];
        a_y0 = lores_reg ? YW'({req.y_coord, 1'b0}) : req.y_coord[YW-1:0];
        a_cx = req.first_row ? a_x0 : dx_reg;
        a_cy = req.first_row ? a_y0 : dy_reg;
        a_clip = req.first_row ? 1'b0 : clip_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        clip_next = clip_reg;
        a_ctl.is_read = 1'b0;
        a_ctl.draw    = 1'b0;
        a_ctl.doubled = lores_reg;
        a_ctl.wide    = req.wide;
        a_ctl.wrap    = wrap_reg;
        a_ctl.clear   = 1'b0;
        a_ctl.clip    = clip_reg;
        a_raddr0 = req.y_coord[YW-1:0];
        if (req.command == xsd_pkg::CMD_READ)
        begin
            a_ctl.is_read = 1'b1;
        end
        else
        begin
            dx_next = a_cx;
            dy_next = a_cy;
            clip_next = a_clip;
            a_ctl.clear = req.first_row;
            a_ctl.draw = !a_clip;
            a_raddr0 = a_cy;
            if (!a_clip)
            begin
                if (!wrap_reg && (a_cy == (lores_reg ? Y_LAST2 : Y_LAST)))
                begin
                    clip_next = 1'b1;
                end
                else
                begin
                    dy_next = a_cy + (lores_reg ? YW'(2) : YW'(1));
                end
            end
            a_ctl.clip = clip_next;
        end
        a_raddr1 = a_raddr0 + YW'(1);
    end

    // configuration and draw state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lores_reg <= 1'b0;
            wrap_reg  <= 1'b0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            clip_reg  <= 1'b0;
            coll_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    xsd_pkg::REG_LORES: lores_reg <= cfg_data;
                    xsd_pkg::REG_WRAP:  wrap_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                dx_reg   <= dx_next;
                dy_reg   <= dy_next;
                clip_reg <= clip_next;
            end
            if (b_adv)
            begin
                coll_reg <= coll_next;
            end
        end
    end

    // draw stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_phase_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                b_valid_reg <= 1'b1;
                b_phase_reg <= 1'b0;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
                b_phase_reg <= 1'b0;
            end
            else if (b_valid_reg && b_two)
            begin
                b_phase_reg <= 1'b1;
            end
        end
    end

    // draw stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_ctl_reg  <= a_ctl;
            b_x_reg    <= a_cx;
            b_y_reg    <= a_raddr0;
            b_y2_reg   <= a_raddr1;
            b_half_reg <= req.x_coord[6];
            b_data_reg <= req.row_data;
        end
    end

    // line write: the drawn line, then the copy line of a doubled row
    assign fb_we    = b_valid_reg && b_ctl_reg.draw;
    assign fb_waddr = b_phase_reg ? b_y2_reg : b_y_reg;
    assign fb_wdata = b_phase_reg ? new1 : new0;

    xsd_fb #(
        .LINE_W (DISPLAY_WIDTH),
        .DEPTH  (DISPLAY_HEIGHT)
    ) u_fb (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (fb_we),
        .waddr  (fb_waddr),
        .wdata  (fb_wdata),
        .re     (accept),
        .raddr0 (a_raddr0),
        .raddr1 (a_raddr1),
        .rdata0 (line0),
        .rdata1 (line1)
    );

    xsd_draw #(
        .LINE_W (DISPLAY_WIDTH)
    ) u_draw (
        .ctl       (b_ctl_reg),
        .x         (b_x_reg),
        .half      (b_half_reg),
        .data      (b_data_reg),
        .line0     (line0),
        .line1     (line1),
        .coll      (coll_reg),
        .new0      (new0),
        .new1      (new1),
        .coll_next (coll_next),
        .read_data (rdata)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            o_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            o_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            o_flag_reg    <= coll_next;
            o_rdata_reg   <= rdata;
            o_stopped_reg <= b_ctl_reg.clip;
        end
    end

    assign rsp.valid      = o_valid_reg;
    assign rsp.flag_value = o_flag_reg;
    assign rsp.read_data  = o_rdata_reg;
    assign rsp.stopped    = o_stopped_reg;

endmodule
